// ===== sv/bae_pkg.sv =====
// ----------------------------------------------------------------------------
// bae_pkg: shared types and constants for the button edge / auto-repeat block
// Field widths, register map codes and reset values of the config registers.
// ----------------------------------------------------------------------------
package bae_pkg;

  localparam int SLOT_W  = 3;
  localparam int BTN_W   = 12;
  localparam int CNT_W   = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam int DEF_PLAYER_SLOTS = 8;
  localparam int DEF_BUTTON_COUNT = 12;

  localparam logic [CNT_W-1:0] FIRST_DELAY_RST     = 5'd18;
  localparam logic [CNT_W-1:0] REPEAT_INTERVAL_RST = 5'd6;

  // bit positions in the button word
  localparam int KEY_RIGHT = 4;
  localparam int KEY_LEFT  = 5;
  localparam int KEY_UP    = 6;
  localparam int KEY_DOWN  = 7;

  // register select, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_FIRST_DELAY     = 1'b0,
    REG_REPEAT_INTERVAL = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CNT_W-1:0] first_delay;
    logic [CNT_W-1:0] repeat_interval;
  } cfg_t;

endpackage

// ===== sv/bae_cfg.sv =====
// ----------------------------------------------------------------------------
// bae_cfg: configuration registers
// APB-style slave holding the first-delay and repeat-interval counts.
// ----------------------------------------------------------------------------
module bae_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bae_pkg::PADDR_W-1:0]   paddr,
  input  logic [bae_pkg::PDATA_W-1:0]   pwdata,
  output logic [bae_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output bae_pkg::cfg_t                 cfg_o
);

  bae_pkg::cfg_t    cfg_q, cfg_d;
  logic             wr_en;
  bae_pkg::reg_idx_e sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign sel    = bae_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        bae_pkg::REG_FIRST_DELAY:
          cfg_d.first_delay = pwdata[bae_pkg::CNT_W-1:0];
        bae_pkg::REG_REPEAT_INTERVAL:
          cfg_d.repeat_interval = pwdata[bae_pkg::CNT_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      bae_pkg::REG_FIRST_DELAY:
        prdata = {{(bae_pkg::PDATA_W-bae_pkg::CNT_W){1'b0}}, cfg_q.first_delay};
      bae_pkg::REG_REPEAT_INTERVAL:
        prdata = {{(bae_pkg::PDATA_W-bae_pkg::CNT_W){1'b0}}, cfg_q.repeat_interval};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_delay     <= bae_pkg::FIRST_DELAY_RST;
      cfg_q.repeat_interval <= bae_pkg::REPEAT_INTERVAL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/button_edge_and_auto_repeat.sv =====
// ----------------------------------------------------------------------------
// button_edge_and_auto_repeat: per-slot button edge detect with auto-repeat
// Cancels opposite directions, reports held/pressed/released and repeat masks.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: one word per frame sample, {buttons, player_slot}.
//   Output stream m_axis_*: one word per input word,
//     {repeat_res, released, pressed, held}.
//   APB port: reg 0 (addr 0x0) first_delay, reg 1 (addr 0x4) repeat_interval.
//   Write config only while no word is in flight.
// Timing:
//   An accepted word is registered in stage 1, then in the output register.
//   One word per cycle sustained while m_axis is not stalled, for any slot
//   sequence: the per-slot row is read at accept and written back as the word
//   leaves stage 1; a same-slot word directly behind gets the fresh row forwarded.
// Reset:
//   Previous-sample store reads as zero per slot until first written (valid
//   bits); counters need no clearing. Config returns to 18 and 6.
// Stall:
//   Result waits in the output register; the stage behind it keeps one more
//   word, and s_axis_tready drops only when both are full.
// ----------------------------------------------------------------------------
module button_edge_and_auto_repeat #(
  parameter int PLAYER_SLOTS = bae_pkg::DEF_PLAYER_SLOTS,
  parameter int BUTTON_COUNT = bae_pkg::DEF_BUTTON_COUNT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // slave stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,  // player_slot[2:0], buttons[14:3]
  // master stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [47:0]                 m_axis_tdata,  // held, pressed, released, repeat_res
  // config
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bae_pkg::PADDR_W-1:0] paddr,
  input  logic [bae_pkg::PDATA_W-1:0] pwdata,
  output logic [bae_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int AW    = (PLAYER_SLOTS > 1) ? $clog2(PLAYER_SLOTS) : 1;
  localparam int BW    = bae_pkg::BTN_W;
  localparam int CW    = bae_pkg::CNT_W;
  localparam int SW    = bae_pkg::SLOT_W;
  localparam int ROW_W = BUTTON_COUNT * CW;
  localparam logic [6:0]    SLOTS_C   = 7'(PLAYER_SLOTS);
  localparam logic [BW-1:0] LIVE_MASK = BW'((13'd1 << BUTTON_COUNT) - 13'd1);

  bae_pkg::cfg_t cfg;

  bae_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------- stage 0
  logic          acc;
  logic [SW-1:0] slot_red;
  logic [AW-1:0] rd_addr;
  logic [BW-1:0] cur_in;

  assign acc = s_axis_tvalid && s_axis_tready;

  // slot modulo PLAYER_SLOTS by repeated subtract (slot is only 3 bits)
  always_comb begin
    slot_red = s_axis_tdata[SW-1:0];
    for (int i = 0; i < 8; i++) begin
      if ({4'b0000, slot_red} >= SLOTS_C) slot_red = slot_red - SW'(PLAYER_SLOTS);
    end
  end
  assign rd_addr = AW'(slot_red);

  always_comb begin
    cur_in = s_axis_tdata[SW +: BW] & LIVE_MASK;
    if (cur_in[bae_pkg::KEY_RIGHT] && cur_in[bae_pkg::KEY_LEFT]) begin
      cur_in[bae_pkg::KEY_RIGHT] = 1'b0;
      cur_in[bae_pkg::KEY_LEFT]  = 1'b0;
    end
    if (cur_in[bae_pkg::KEY_UP] && cur_in[bae_pkg::KEY_DOWN]) begin
      cur_in[bae_pkg::KEY_UP]   = 1'b0;
      cur_in[bae_pkg::KEY_DOWN] = 1'b0;
    end
  end

  // ---------------------------------------------------------------- memories
  logic [BW-1:0]    prev_mem [PLAYER_SLOTS];
  logic [ROW_W-1:0] cnt_mem  [PLAYER_SLOTS];
  logic [BW-1:0]    prev_rd_q;
  logic [ROW_W-1:0] cnt_rd_q;
  logic             wr_en;
  logic [ROW_W-1:0] cnt_new;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      prev_rd_q <= prev_mem[rd_addr];
      cnt_rd_q  <= cnt_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic                   s1_vld_q, s1_vld_d;
  logic                   s1_adv;
  logic [AW-1:0]          s1_addr_q;
  logic [BW-1:0]          s1_cur_q;
  logic                   fwd_q, pvld_q;
  logic [BW-1:0]          fwd_prev_q;
  logic [ROW_W-1:0]       fwd_cnt_q;
  logic [PLAYER_SLOTS-1:0] vld_q;
  logic                   out_vld_q, out_vld_d;
  logic [4*BW-1:0]        out_data_q;

  logic [BW-1:0]    prev, down, up, rep;
  logic [ROW_W-1:0] cnt_row;

  assign s1_adv        = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !s1_vld_q || s1_adv;
  assign wr_en         = s1_vld_q && s1_adv;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      prev_mem[s1_addr_q] <= s1_cur_q;
      cnt_mem[s1_addr_q]  <= cnt_new;
    end
  end

  // row as seen by the word in stage 1: forwarded, stored, or reset value
  always_comb begin
    if (fwd_q) begin
      prev    = fwd_prev_q;
      cnt_row = fwd_cnt_q;
    end else begin
      prev    = pvld_q ? prev_rd_q : '0;
      cnt_row = cnt_rd_q;
    end
  end

  assign down = s1_cur_q & ~prev;
  assign up   = prev & ~s1_cur_q;

  always_comb begin
    rep     = '0;
    cnt_new = cnt_row;
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      if (s1_cur_q[b]) begin
        if (down[b]) begin
          cnt_new[b*CW +: CW] = cfg.first_delay;
          rep[b]              = 1'b1;
        end else if (cnt_row[b*CW +: CW] == '0) begin
          cnt_new[b*CW +: CW] = cfg.repeat_interval;
          rep[b]              = 1'b1;
        end else begin
          cnt_new[b*CW +: CW] = cnt_row[b*CW +: CW] - CW'(1);
        end
      end
    end
  end

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (acc)         s1_vld_d = 1'b1;
    else if (s1_adv) s1_vld_d = 1'b0;
    out_vld_d = out_vld_q;
    if (wr_en)              out_vld_d = 1'b1;
    else if (m_axis_tready) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      vld_q     <= '0;
      fwd_q     <= 1'b0;
      pvld_q    <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
      if (wr_en) vld_q[s1_addr_q] <= 1'b1;
      if (acc) begin
        fwd_q  <= wr_en && (s1_addr_q == rd_addr);
        pvld_q <= vld_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_addr_q  <= rd_addr;
      s1_cur_q   <= cur_in;
      fwd_prev_q <= s1_cur_q;
      fwd_cnt_q  <= cnt_new;
    end
    if (wr_en) out_data_q <= {rep, up, down, s1_cur_q};
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------- checks
  a_no_held_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_data_q[BW-1:0] & out_data_q[2*BW +: BW]) == '0)
    else $error("button both held and released");

  a_press_fires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_data_q[BW +: BW] & ~out_data_q[3*BW +: BW]) == '0)
    else $error("new press did not fire a repeat");

  a_repeat_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_data_q[3*BW +: BW] & ~out_data_q[BW-1:0]) == '0)
    else $error("repeat on a button not held");

  a_lr_cancel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_data_q[bae_pkg::KEY_LEFT] && out_data_q[bae_pkg::KEY_RIGHT]))
    else $error("left and right both held");

  a_fwd_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && fwd_q) |-> vld_q[s1_addr_q])
    else $error("forwarded row from a slot never written");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: button edge detect and auto-repeat, self-checking
// Streams per-slot button samples through the block under random idling on
// both sides, predicts held/pressed/released/repeat masks and checks each
// output word in order. Delay and interval registers are rewritten between
// phases.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_PHASES   = 6;
  localparam int RAND_ITEMS   = 310;
  localparam int HOLD_OFF     = 200;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_LIMIT = 100;

  typedef struct packed {
    logic [bae_pkg::BTN_W-1:0] repeat_res;
    logic [bae_pkg::BTN_W-1:0] released;
    logic [bae_pkg::BTN_W-1:0] pressed;
    logic [bae_pkg::BTN_W-1:0] held;
  } frame_t;

  // Tracks per-slot button history and typematic counters.
  class repeat_tracker;
    logic [bae_pkg::BTN_W-1:0] last_held [bae_pkg::DEF_PLAYER_SLOTS];
    logic [bae_pkg::CNT_W-1:0] repeat_count [bae_pkg::DEF_PLAYER_SLOTS][bae_pkg::BTN_W];
    logic [bae_pkg::CNT_W-1:0] first_delay;
    logic [bae_pkg::CNT_W-1:0] repeat_interval;
    frame_t expected_frames [$];
    int errors;
    int reported;
    int frames_checked;
    int repeat_ticks;

    function new();
      first_delay     = bae_pkg::FIRST_DELAY_RST;
      repeat_interval = bae_pkg::REPEAT_INTERVAL_RST;
      foreach (last_held[s]) last_held[s] = '0;
      foreach (repeat_count[s, b]) repeat_count[s][b] = '0;
      errors         = 0;
      reported       = 0;
      frames_checked = 0;
      repeat_ticks   = 0;
    endfunction

    function void take_sample(logic [bae_pkg::SLOT_W-1:0] slot,
                              logic [bae_pkg::BTN_W-1:0] raw);
      frame_t f;
      logic [bae_pkg::BTN_W-1:0] cur;
      logic [bae_pkg::BTN_W-1:0] prev;
      cur = raw;
      if (cur[bae_pkg::KEY_RIGHT] && cur[bae_pkg::KEY_LEFT]) begin
        cur[bae_pkg::KEY_RIGHT] = 1'b0;
        cur[bae_pkg::KEY_LEFT]  = 1'b0;
      end
      if (cur[bae_pkg::KEY_UP] && cur[bae_pkg::KEY_DOWN]) begin
        cur[bae_pkg::KEY_UP]   = 1'b0;
        cur[bae_pkg::KEY_DOWN] = 1'b0;
      end
      prev            = last_held[slot];
      f.held          = cur;
      f.pressed       = cur & ~prev;
      f.released      = prev & ~cur;
      f.repeat_res    = '0;
      last_held[slot] = cur;
      for (int b = 0; b < bae_pkg::BTN_W; b++) begin
        if (cur[b]) begin
          if (f.pressed[b]) begin
            repeat_count[slot][b] = first_delay;
            f.repeat_res[b] = 1'b1;
          end else if (repeat_count[slot][b] == '0) begin
            repeat_count[slot][b] = repeat_interval;
            f.repeat_res[b] = 1'b1;
          end else begin
            repeat_count[slot][b] = repeat_count[slot][b] - 1'b1;
          end
        end
      end
      expected_frames.push_back(f);
    endfunction

    function void compare_field(string name, logic [bae_pkg::BTN_W-1:0] want,
                                logic [bae_pkg::BTN_W-1:0] got);
      if (want !== got) begin
        errors++;
        if (reported < REPORT_LIMIT) begin
          $display("%0t: %s mismatch, expected %03h, actual %03h", $time, name, want, got);
          reported++;
        end
      end
    endfunction

    function void check_frame(frame_t got);
      frame_t want;
      if (expected_frames.size() == 0) begin
        errors++;
        if (reported < REPORT_LIMIT) begin
          $display("%0t: unexpected output word, expected none, actual %012h", $time, got);
          reported++;
        end
        return;
      end
      want = expected_frames.pop_front();
      frames_checked++;
      if ((want.repeat_res & ~want.pressed) != '0) repeat_ticks++;
      compare_field("held", want.held, got.held);
      compare_field("pressed", want.pressed, got.pressed);
      compare_field("released", want.released, got.released);
      compare_field("repeat_res", want.repeat_res, got.repeat_res);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata;  // player_slot[2:0], buttons[14:3]
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [47:0] m_axis_tdata;  // held, pressed, released, repeat_res
  logic psel;
  logic penable;
  logic pwrite;
  logic [bae_pkg::PADDR_W-1:0] paddr;
  logic [bae_pkg::PDATA_W-1:0] pwdata;
  logic [bae_pkg::PDATA_W-1:0] prdata;
  logic pready;

  repeat_tracker tracker;
  int  cycle_count = 0;
  int  input_stalls = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;
  bit  hold_off_req = 1'b0;
  logic [bae_pkg::BTN_W-1:0] pad_state [bae_pkg::DEF_PLAYER_SLOTS];

  button_edge_and_auto_repeat dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // word monitor: both handshakes sampled at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        tracker.take_sample(s_axis_tdata[2:0], s_axis_tdata[14:3]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check_frame(frame_t'(m_axis_tdata));
      end
      if (s_axis_tvalid && !s_axis_tready) input_stalls++;
    end
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk_i);
      end
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_sample(logic [bae_pkg::SLOT_W-1:0] slot,
                             logic [bae_pkg::BTN_W-1:0] buttons);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, buttons, slot};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.expected_frames.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(bae_pkg::reg_idx_e idx, logic [bae_pkg::PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == bae_pkg::REG_FIRST_DELAY) tracker.first_delay = value[bae_pkg::CNT_W-1:0];
    else tracker.repeat_interval = value[bae_pkg::CNT_W-1:0];
    // idle cycle so a following write starts with a fresh setup phase
    @(posedge clk_i);
  endtask

  // random frame: mostly a slot's previous sample held or with one bit toggled
  task automatic send_random_frame(ref logic [bae_pkg::SLOT_W-1:0] hot_slot);
    logic [bae_pkg::SLOT_W-1:0] slot;
    int pick;
    if ($urandom_range(0, 49) == 0) hot_slot = bae_pkg::SLOT_W'($urandom_range(0, 7));
    slot = ($urandom_range(0, 3) == 0) ? bae_pkg::SLOT_W'($urandom_range(0, 7)) : hot_slot;
    pick = $urandom_range(0, 31);
    if (pick == 0) pad_state[slot] = bae_pkg::BTN_W'($urandom_range(0, 4095));
    else if (pick <= 3) pad_state[slot][$urandom_range(0, bae_pkg::BTN_W - 1)] ^= 1'b1;
    send_sample(slot, pad_state[slot]);
  endtask

  localparam logic [14:0] OPENING_FRAMES [22] = '{
    {3'd0, 12'h000}, {3'd0, 12'hFFF}, {3'd0, 12'hFFF}, {3'd0, 12'h000},
    {3'd1, 12'h030}, {3'd1, 12'h0C0}, {3'd1, 12'h010}, {3'd1, 12'h030},
    {3'd1, 12'h040}, {3'd1, 12'h0C0}, {3'd1, 12'h080}, {3'd1, 12'h0B0},
    {3'd2, 12'hAAA}, {3'd2, 12'h555}, {3'd3, 12'hF0F}, {3'd3, 12'hF0F},
    {3'd4, 12'h001}, {3'd4, 12'h000}, {3'd5, 12'h0F0}, {3'd6, 12'hFFF},
    {3'd7, 12'h800}, {3'd7, 12'h801}
  };

  initial begin
    logic [bae_pkg::PDATA_W-1:0] delay_val [NUM_PHASES];
    logic [bae_pkg::PDATA_W-1:0] interval_val [NUM_PHASES];
    logic [bae_pkg::SLOT_W-1:0] hot_slot;
    tracker = new();
    foreach (pad_state[s]) pad_state[s] = '0;
    hot_slot = '0;
    delay_val    = '{32'd18, 32'd0, 32'd31, 32'hFFFF_FFE3, $urandom, $urandom};
    interval_val = '{32'd6, 32'd0, 32'd31, 32'h0000_0021, $urandom, $urandom};

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        apb_write(bae_pkg::REG_FIRST_DELAY, delay_val[phase]);
        apb_write(bae_pkg::REG_REPEAT_INTERVAL, interval_val[phase]);
      end
      if (phase == 0) begin
        foreach (OPENING_FRAMES[i]) begin
          send_sample(OPENING_FRAMES[i][14:12], OPENING_FRAMES[i][11:0]);
        end
      end else if (phase == 1) begin
        // zero delay: a held button fires on every frame
        repeat (5) send_sample(3'd2, 12'h001);
        send_sample(3'd2, 12'h000);
      end else if (phase == 2) begin
        // back up the output so the input stalls
        tx_burst = 1'b1;
        hold_off_req = 1'b1;
      end
      repeat (RAND_ITEMS) send_random_frame(hot_slot);
      drain();
    end

    $display("checked %0d frames over %0d delay/interval settings, %0d with auto-repeat",
             tracker.frames_checked, NUM_PHASES, tracker.repeat_ticks);
    $display("input held off for %0d cycles with the output backed up", input_stalls);
    if (tracker.errors == 0 && tracker.expected_frames.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
